// ===== rtl/core/erms_pkg.sv =====
// Package: shared types, constants and codes for the echo ranger with median smoothing.
package erms_pkg;

   localparam int WIN_LEN = 5;
   localparam int IDX_W   = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
   localparam int CNT_W   = $clog2(WIN_LEN + 1);

   localparam int TIME_W  = 32;
   localparam int PULSE_W = 16;
   localparam int SCALE_W = 12;
   localparam int DIST_W  = 28;
   localparam int CSR_A_W = 2;
   localparam int CSR_D_W = 16;

   localparam logic [PULSE_W-1:0] TIMEOUT_RST   = 16'd38000;
   localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd40000;
   localparam logic [SCALE_W-1:0] SCALE_RST     = 12'd1114;

   typedef enum logic [1:0] {
      CMD_TRIGGER = 2'd0,
      CMD_EDGE    = 2'd1,
      CMD_POLL    = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_DONE = 2'd2,
      PH_LOST = 2'd3
   } phase_type;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_TIMEOUT   = 2'd0,
      CSR_MAX_PULSE = 2'd1,
      CSR_SCALE     = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_PUSH,
      ST_RANK,
      ST_SMOOTH,
      ST_POST
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [TIME_W-1:0] time_us;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              meas_lost;
      logic [1:0]        phase;
      logic              fire_trigger;
      logic              updated;
   } rsp_type;

   typedef struct packed {
      logic latch;
      logic eval;
      logic mul;
      logic push;
      logic rank;
      logic smooth;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic measure;
      logic rank_last;
      logic out_free;
   } dp_sts_type;

endpackage

// ===== rtl/core/erms_ctrl.sv =====
// Controller: sequences one transaction through evaluate, multiply, median and smoothing.
module erms_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output erms_pkg::dp_cmd_type   cmd,
   input  erms_pkg::dp_sts_type   sts
);

   erms_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= erms_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         erms_pkg::ST_IDLE: begin
            if (req_valid) state_in = erms_pkg::ST_EVAL;
         end
         erms_pkg::ST_EVAL: begin
            state_in = sts.measure ? erms_pkg::ST_MUL : erms_pkg::ST_POST;
         end
         erms_pkg::ST_MUL:    state_in = erms_pkg::ST_PUSH;
         erms_pkg::ST_PUSH:   state_in = erms_pkg::ST_RANK;
         erms_pkg::ST_RANK: begin
            if (sts.rank_last) state_in = erms_pkg::ST_SMOOTH;
         end
         erms_pkg::ST_SMOOTH: state_in = erms_pkg::ST_POST;
         erms_pkg::ST_POST: begin
            if (sts.out_free) state_in = erms_pkg::ST_IDLE;
         end
         default:             state_in = erms_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         erms_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.latch = req_valid;
         end
         erms_pkg::ST_EVAL:   cmd.eval     = 1'b1;
         erms_pkg::ST_MUL:    cmd.mul      = 1'b1;
         erms_pkg::ST_PUSH:   cmd.push     = 1'b1;
         erms_pkg::ST_RANK:   cmd.rank     = 1'b1;
         erms_pkg::ST_SMOOTH: cmd.smooth   = 1'b1;
         erms_pkg::ST_POST:   cmd.load_out = sts.out_free;
         default: begin
            cmd       = '0;
            req_stall = 1'b1;
         end
      endcase
   end

   ctrl_no_overlap_a: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("controller issued more than one datapath command");

   ctrl_accept_idle_a: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |=> state_ff == erms_pkg::ST_EVAL)
      else $error("accepted transaction not followed by evaluation");

   ctrl_load_ret_a: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> !req_stall)
      else $error("controller not ready after loading a result");

endmodule

// ===== rtl/core/erms_dp.sv =====
// Datapath: ranging state, configuration, scaling multiply, median window and smoothing.
module erms_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  erms_pkg::req_type                  req_data,
   input  logic                               csr_we,
   input  logic [erms_pkg::CSR_A_W-1:0]       csr_index,
   input  logic [erms_pkg::CSR_D_W-1:0]       csr_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output erms_pkg::rsp_type                  rsp_data,
   input  erms_pkg::dp_cmd_type               cmd,
   output erms_pkg::dp_sts_type               sts
);

   logic [erms_pkg::PULSE_W-1:0] timeout_ff, timeout_in;
   logic [erms_pkg::PULSE_W-1:0] max_pulse_ff, max_pulse_in;
   logic [erms_pkg::SCALE_W-1:0] scale_ff, scale_in;

   erms_pkg::phase_type          phase_ff, phase_in;
   logic                         seen_ff, seen_in;
   logic                         lost_ff, lost_in;
   logic                         fire_ff, fire_in;
   logic                         upd_ff, upd_in;
   logic [erms_pkg::TIME_W-1:0]  start_ff, start_in;
   logic [erms_pkg::TIME_W-1:0]  end_ff, end_in;
   logic [erms_pkg::DIST_W-1:0]  smoothed_ff, smoothed_in;

   logic [1:0]                   cmd_code_ff, cmd_code_in;
   logic [erms_pkg::TIME_W-1:0]  time_ff, time_in;

   logic [erms_pkg::DIST_W-1:0]  raw_ff, raw_in;
   logic [erms_pkg::DIST_W-1:0]  med_ff, med_in;
   logic [erms_pkg::DIST_W-1:0]  win_ff [erms_pkg::WIN_LEN];
   logic [erms_pkg::DIST_W-1:0]  win_in [erms_pkg::WIN_LEN];
   logic [erms_pkg::IDX_W-1:0]   pos_ff, pos_in;
   logic [erms_pkg::CNT_W-1:0]   fill_ff, fill_in;
   logic [erms_pkg::IDX_W-1:0]   cand_ff, cand_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   erms_pkg::rsp_type            rsp_ff, rsp_in;

   logic [erms_pkg::TIME_W-1:0]  width_w;
   logic [erms_pkg::TIME_W-1:0]  elapsed_w;
   logic                         width_ok;
   logic [erms_pkg::DIST_W-1:0]  cand_val;
   logic [erms_pkg::CNT_W-1:0]   lt_cnt, le_cnt, mid_k;

   assign width_w   = end_ff - start_ff;
   assign elapsed_w = time_ff - start_ff;
   assign width_ok  = (width_w != '0) &&
                      (width_w <= erms_pkg::TIME_W'(max_pulse_ff));

   assign cand_val = win_ff[cand_ff];
   assign mid_k    = fill_ff >> 1;

   always_comb begin
      lt_cnt = '0;
      le_cnt = '0;
      for (int j = 0; j < erms_pkg::WIN_LEN; j++) begin
         if (erms_pkg::CNT_W'(j) < fill_ff) begin
            if (win_ff[j] < cand_val)  lt_cnt = lt_cnt + erms_pkg::CNT_W'(1);
            if (win_ff[j] <= cand_val) le_cnt = le_cnt + erms_pkg::CNT_W'(1);
         end
      end
   end

   assign sts.measure   = (cmd_code_ff == erms_pkg::CMD_POLL) &&
                          (phase_ff == erms_pkg::PH_DONE) && width_ok;
   assign sts.rank_last = (erms_pkg::CNT_W'(cand_ff) + erms_pkg::CNT_W'(1)) == fill_ff;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      timeout_in   = timeout_ff;
      max_pulse_in = max_pulse_ff;
      scale_in     = scale_ff;
      if (csr_we) begin
         case (csr_index)
            erms_pkg::CSR_TIMEOUT:   timeout_in   = csr_data;
            erms_pkg::CSR_MAX_PULSE: max_pulse_in = csr_data;
            erms_pkg::CSR_SCALE:     scale_in     = csr_data[erms_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      seen_in     = seen_ff;
      lost_in     = lost_ff;
      fire_in     = fire_ff;
      upd_in      = upd_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      smoothed_in = smoothed_ff;
      cmd_code_in = cmd_code_ff;
      time_in     = time_ff;
      raw_in      = raw_ff;
      med_in      = med_ff;
      win_in      = win_ff;
      pos_in      = pos_ff;
      fill_in     = fill_ff;
      cand_in     = cand_ff;

      if (cmd.latch) begin
         cmd_code_in = req_data.command;
         time_in     = req_data.time_us;
      end

      if (cmd.eval) begin
         fire_in = 1'b0;
         upd_in  = 1'b0;
         case (cmd_code_ff)
            erms_pkg::CMD_TRIGGER: begin
               if (phase_ff == erms_pkg::PH_IDLE) begin
                  start_in = time_ff;
                  seen_in  = 1'b0;
                  phase_in = erms_pkg::PH_WAIT;
                  fire_in  = 1'b1;
               end
            end
            erms_pkg::CMD_EDGE: begin
               if (phase_ff == erms_pkg::PH_WAIT) begin
                  if (!seen_ff) begin
                     start_in = time_ff;
                     seen_in  = 1'b1;
                  end else begin
                     end_in   = time_ff;
                     phase_in = erms_pkg::PH_DONE;
                  end
               end
            end
            erms_pkg::CMD_POLL: begin
               case (phase_ff)
                  erms_pkg::PH_WAIT: begin
                     if (elapsed_w >= erms_pkg::TIME_W'(timeout_ff))
                        phase_in = erms_pkg::PH_LOST;
                  end
                  erms_pkg::PH_DONE: begin
                     if (!width_ok) phase_in = erms_pkg::PH_LOST;
                  end
                  erms_pkg::PH_LOST: begin
                     lost_in  = 1'b1;
                     seen_in  = 1'b0;
                     fill_in  = '0;
                     pos_in   = '0;
                     phase_in = erms_pkg::PH_IDLE;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end

      // width is at most 16 bits here, so the product never exceeds 28 bits
      if (cmd.mul) begin
         raw_in = erms_pkg::DIST_W'(width_w[erms_pkg::PULSE_W-1:0]) *
                  erms_pkg::DIST_W'(scale_ff);
      end

      if (cmd.push) begin
         win_in[pos_ff] = raw_ff;
         if (pos_ff == erms_pkg::IDX_W'(erms_pkg::WIN_LEN - 1)) pos_in = '0;
         else                                                   pos_in = pos_ff + 1'b1;
         if (fill_ff < erms_pkg::CNT_W'(erms_pkg::WIN_LEN))
            fill_in = fill_ff + erms_pkg::CNT_W'(1);
         cand_in = '0;
      end

      if (cmd.rank) begin
         if ((lt_cnt <= mid_k) && (mid_k < le_cnt)) med_in = cand_val;
         cand_in = cand_ff + 1'b1;
      end

      if (cmd.smooth) begin
         if ((smoothed_ff == '0) || lost_ff)
            smoothed_in = med_ff;
         else
            smoothed_in = smoothed_ff - (smoothed_ff >> 2) + (med_ff >> 2);
         lost_in  = 1'b0;
         seen_in  = 1'b0;
         phase_in = erms_pkg::PH_IDLE;
         upd_in   = 1'b1;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_out) begin
         rsp_valid_in        = 1'b1;
         rsp_in.distance     = smoothed_ff;
         rsp_in.meas_lost    = lost_ff;
         rsp_in.phase        = phase_ff;
         rsp_in.fire_trigger = fire_ff;
         rsp_in.updated      = upd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= erms_pkg::TIMEOUT_RST;
         max_pulse_ff <= erms_pkg::MAX_PULSE_RST;
         scale_ff     <= erms_pkg::SCALE_RST;
         phase_ff     <= erms_pkg::PH_IDLE;
         seen_ff      <= 1'b0;
         lost_ff      <= 1'b0;
         fire_ff      <= 1'b0;
         upd_ff       <= 1'b0;
         start_ff     <= '0;
         end_ff       <= '0;
         smoothed_ff  <= '0;
         pos_ff       <= '0;
         fill_ff      <= '0;
         cand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         timeout_ff   <= timeout_in;
         max_pulse_ff <= max_pulse_in;
         scale_ff     <= scale_in;
         phase_ff     <= phase_in;
         seen_ff      <= seen_in;
         lost_ff      <= lost_in;
         fire_ff      <= fire_in;
         upd_ff       <= upd_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         smoothed_ff  <= smoothed_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         cand_ff      <= cand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_code_ff <= cmd_code_in;
      time_ff     <= time_in;
      raw_ff      <= raw_in;
      med_ff      <= med_in;
      win_ff      <= win_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   dp_fill_range_a: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= erms_pkg::CNT_W'(erms_pkg::WIN_LEN))
      else $error("window fill count out of range");

   dp_pos_range_a: assert property (@(posedge clock) disable iff (reset)
      pos_ff < erms_pkg::IDX_W'(erms_pkg::WIN_LEN))
      else $error("window write pointer out of range");

   dp_rank_bound_a: assert property (@(posedge clock) disable iff (reset)
      cmd.rank |-> erms_pkg::CNT_W'(cand_ff) < fill_ff)
      else $error("median candidate beyond filled window");

   dp_no_overwrite_a: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

endmodule

// ===== rtl/core/echo_ranger_median_smooth.sv =====
// Top level: ultrasonic echo ranging channel with median-of-five and quarter-weight smoothing.
// Timing: a transaction is latched in idle and evaluated; a poll that completes a
// measurement is then multiplied, pushed, ranked and smoothed before the result is loaded.
// A new transaction is taken only after the last result is loaded into the output; the median
// search visits one window entry per cycle.
// Reset: synchronous; state and configuration registers take their defaults at once, no clearing pass.
module echo_ranger_median_smooth (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  erms_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output erms_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [erms_pkg::CSR_A_W-1:0]       csr_index,
   input  logic [erms_pkg::CSR_D_W-1:0]       csr_data
);

   erms_pkg::dp_cmd_type dp_cmd;
   erms_pkg::dp_sts_type dp_sts;
   logic                 csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   erms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (dp_cmd),
      .sts       (dp_sts)
   );

   erms_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (dp_cmd),
      .sts       (dp_sts)
   );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the echo ranger with median-of-five and quarter-weight smoothing.
`timescale 1ns / 1ps

module tb_top;

   localparam int          LIMIT_CYCLES = 400000;
   localparam int          REPORT_MAX   = 100;
   localparam logic [1:0]  CMD_RESERVED = 2'd3;
   localparam logic [1:0]  CSR_UNUSED   = 2'd3;
   localparam logic [63:0] DIST_TOP     = 64'h0FFF_FFFF;

   typedef struct packed {
      logic [erms_pkg::CSR_A_W-1:0] index;
      logic [erms_pkg::CSR_D_W-1:0] value;
   } csr_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid = 1'b0;
   logic                         req_stall;
   erms_pkg::req_type            req_data  = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   erms_pkg::rsp_type            rsp_data;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [erms_pkg::CSR_A_W-1:0] csr_index = '0;
   logic [erms_pkg::CSR_D_W-1:0] csr_data  = '0;

   echo_ranger_median_smooth i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ranger shadow state
   logic [erms_pkg::PULSE_W-1:0] cfg_timeout   = erms_pkg::TIMEOUT_RST;
   logic [erms_pkg::PULSE_W-1:0] cfg_max_pulse = erms_pkg::MAX_PULSE_RST;
   logic [erms_pkg::SCALE_W-1:0] cfg_scale     = erms_pkg::SCALE_RST;

   erms_pkg::phase_type         ph_now      = erms_pkg::PH_IDLE;
   logic                        echo_armed  = 1'b0;
   logic [erms_pkg::TIME_W-1:0] stamp_start = '0;
   logic [erms_pkg::TIME_W-1:0] stamp_end   = '0;
   logic [erms_pkg::DIST_W-1:0] dist_smooth = '0;
   logic                        lost_state  = 1'b0;
   logic [erms_pkg::DIST_W-1:0] win_buf [erms_pkg::WIN_LEN] = '{default: '0};
   int                          win_pos  = 0;
   int                          win_fill = 0;

   erms_pkg::req_type commands_pending [$];
   erms_pkg::rsp_type readings_due [$];
   csr_write_type     csr_pending [$];

   int   errors = 0;
   int   cmds_sent = 0;
   int   cmds_taken = 0;
   int   csr_sent = 0;
   int   csr_taken = 0;
   int   readings_checked = 0;
   int   distance_updates = 0;
   int   losses = 0;
   int   settings_used = 1;
   int   req_gap = 0;
   int   stall_left = 0;
   int   cycles = 0;
   bit   req_idle_on = 1'b1;
   bit   rsp_idle_on = 1'b1;
   logic [erms_pkg::TIME_W-1:0] clk_us;
   erms_pkg::rsp_type want;

   function automatic erms_pkg::rsp_type ranger_step(input erms_pkg::req_type r);
      erms_pkg::rsp_type           res;
      logic [erms_pkg::TIME_W-1:0] width;
      logic [63:0]                 raw;
      logic [63:0]                 s;
      logic [erms_pkg::DIST_W-1:0] med;
      logic [erms_pkg::DIST_W-1:0] v;
      logic [erms_pkg::DIST_W-1:0] srt [erms_pkg::WIN_LEN];
      int                          i;
      int                          j;
      logic                        fire;
      logic                        upd;
      fire = 1'b0;
      upd  = 1'b0;
      case (r.command)
         erms_pkg::CMD_TRIGGER: begin
            if (ph_now == erms_pkg::PH_IDLE) begin
               stamp_start = r.time_us;
               echo_armed  = 1'b0;
               ph_now      = erms_pkg::PH_WAIT;
               fire        = 1'b1;
            end
         end
         erms_pkg::CMD_EDGE: begin
            if (ph_now == erms_pkg::PH_WAIT) begin
               if (!echo_armed) begin
                  stamp_start = r.time_us;
                  echo_armed  = 1'b1;
               end else begin
                  stamp_end = r.time_us;
                  ph_now    = erms_pkg::PH_DONE;
               end
            end
         end
         erms_pkg::CMD_POLL: begin
            if (ph_now == erms_pkg::PH_WAIT) begin
               if (erms_pkg::TIME_W'(r.time_us - stamp_start) >=
                   erms_pkg::TIME_W'(cfg_timeout)) begin
                  ph_now = erms_pkg::PH_LOST;
                  losses++;
               end
            end else if (ph_now == erms_pkg::PH_DONE) begin
               width = stamp_end - stamp_start;
               if (width == 0 || width > erms_pkg::TIME_W'(cfg_max_pulse)) begin
                  ph_now = erms_pkg::PH_LOST;
                  losses++;
               end else begin
                  raw = 64'(width) * 64'(cfg_scale);
                  if (raw > DIST_TOP)
                     raw = DIST_TOP;
                  if (win_pos >= erms_pkg::WIN_LEN)
                     win_pos = 0;
                  win_buf[win_pos] = raw[erms_pkg::DIST_W-1:0];
                  win_pos++;
                  if (win_pos >= erms_pkg::WIN_LEN)
                     win_pos = 0;
                  if (win_fill < erms_pkg::WIN_LEN)
                     win_fill++;
                  for (i = 0; i < win_fill; i++) begin
                     v = win_buf[i];
                     j = i;
                     while (j > 0 && srt[j-1] > v) begin
                        srt[j] = srt[j-1];
                        j--;
                     end
                     srt[j] = v;
                  end
                  med = srt[win_fill / 2];
                  if (dist_smooth == 0 || lost_state) begin
                     dist_smooth = med;
                  end else begin
                     s = 64'(dist_smooth) - 64'(dist_smooth >> 2) + 64'(med >> 2);
                     dist_smooth = (s > DIST_TOP) ? DIST_TOP[erms_pkg::DIST_W-1:0]
                                                  : s[erms_pkg::DIST_W-1:0];
                  end
                  lost_state = 1'b0;
                  echo_armed = 1'b0;
                  ph_now     = erms_pkg::PH_IDLE;
                  upd        = 1'b1;
               end
            end else if (ph_now == erms_pkg::PH_LOST) begin
               lost_state = 1'b1;
               echo_armed = 1'b0;
               win_fill   = 0;
               win_pos    = 0;
               ph_now     = erms_pkg::PH_IDLE;
            end
         end
         default: ;
      endcase
      res.distance     = dist_smooth;
      res.meas_lost    = lost_state;
      res.phase        = ph_now;
      res.fire_trigger = fire;
      res.updated      = upd;
      return res;
   endfunction

   task automatic report(input string msg);
      errors++;
      if (errors <= REPORT_MAX)
         $display("%0t: %s", $time, msg);
   endtask

   // command driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            readings_due.push_back(ranger_step(req_data));
            cmds_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (commands_pending.size() != 0) begin
               if (req_idle_on && $urandom_range(0, 99) < 20) begin
                  req_gap = $urandom_range(1, 5) - 1;
                  req_valid <= 1'b0;
               end else begin
                  req_data  <= commands_pending.pop_front();
                  req_valid <= 1'b1;
                  cmds_sent++;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // register write driver
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               erms_pkg::CSR_TIMEOUT:   cfg_timeout   = csr_data;
               erms_pkg::CSR_MAX_PULSE: cfg_max_pulse = csr_data;
               erms_pkg::CSR_SCALE:     cfg_scale     = csr_data[erms_pkg::SCALE_W-1:0];
               default: ;
            endcase
            csr_taken++;
         end
         if (!csr_valid || csr_ready) begin
            if (csr_pending.size() != 0) begin
               csr_index <= csr_pending[0].index;
               csr_data  <= csr_pending[0].value;
               csr_valid <= 1'b1;
               void'(csr_pending.pop_front());
               csr_sent++;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (readings_due.size() == 0) begin
               report($sformatf("result with none expected: actual %h", rsp_data));
            end else begin
               want = readings_due.pop_front();
               if (rsp_data.distance !== want.distance)
                  report($sformatf("distance expected %0d actual %0d",
                                   want.distance, rsp_data.distance));
               if (rsp_data.meas_lost !== want.meas_lost)
                  report($sformatf("meas_lost expected %0b actual %0b",
                                   want.meas_lost, rsp_data.meas_lost));
               if (rsp_data.phase !== want.phase)
                  report($sformatf("phase expected %0d actual %0d",
                                   want.phase, rsp_data.phase));
               if (rsp_data.fire_trigger !== want.fire_trigger)
                  report($sformatf("fire_trigger expected %0b actual %0b",
                                   want.fire_trigger, rsp_data.fire_trigger));
               if (rsp_data.updated !== want.updated)
                  report($sformatf("updated expected %0b actual %0b",
                                   want.updated, rsp_data.updated));
               readings_checked++;
               if (want.updated)
                  distance_updates++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 99) < 20) begin
            stall_left = $urandom_range(1, 5) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic push_item(input logic [1:0] cmd, input logic [erms_pkg::TIME_W-1:0] t);
      erms_pkg::req_type r;
      r.command = cmd;
      r.time_us = t;
      commands_pending.push_back(r);
   endtask

   function automatic logic [erms_pkg::TIME_W-1:0] pick_width();
      int k;
      k = $urandom_range(0, 99);
      if (cfg_max_pulse == 0)
         return $urandom_range(0, 100);
      if (k < 5)
         return '0;
      if (k < 10)
         return erms_pkg::TIME_W'(cfg_max_pulse) + $urandom_range(1, 2000);
      if (k < 15)
         return erms_pkg::TIME_W'(cfg_max_pulse);
      if (k < 50)
         return $urandom_range(1, (cfg_max_pulse < 300) ? cfg_max_pulse : 300);
      return $urandom_range(1, cfg_max_pulse);
   endfunction

   task automatic queue_measurement();
      int                          kind;
      int                          k;
      logic [erms_pkg::TIME_W-1:0] t0;
      logic [erms_pkg::TIME_W-1:0] t1;
      logic [erms_pkg::TIME_W-1:0] w;
      kind = $urandom_range(0, 99);
      clk_us = clk_us + $urandom_range(1, 3000);
      t0 = clk_us;
      if (kind < 60) begin
         push_item(erms_pkg::CMD_TRIGGER, t0);
         t1 = t0 + $urandom_range(1, 600);
         if ($urandom_range(0, 4) == 0)
            push_item(erms_pkg::CMD_POLL, t1 - 1);
         push_item(erms_pkg::CMD_EDGE, t1);
         w = pick_width();
         if ($urandom_range(0, 4) == 0)
            push_item(erms_pkg::CMD_POLL, t1 + w / 2);
         push_item(erms_pkg::CMD_EDGE, t1 + w);
         push_item(erms_pkg::CMD_POLL, t1 + w + $urandom_range(1, 50));
         if ($urandom_range(0, 9) < 7)
            push_item(erms_pkg::CMD_POLL, t1 + w + $urandom_range(51, 100));
         clk_us = t1 + w + 200;
      end else if (kind < 80) begin
         push_item(erms_pkg::CMD_TRIGGER, t0);
         if ($urandom_range(0, 1) == 1) begin
            t0 = t0 + $urandom_range(1, 400);
            push_item(erms_pkg::CMD_EDGE, t0);
         end
         if (cfg_timeout != 0 && $urandom_range(0, 9) < 3)
            push_item(erms_pkg::CMD_POLL, t0 + cfg_timeout - 1);
         t1 = t0 + cfg_timeout + $urandom_range(0, 2);
         push_item(erms_pkg::CMD_POLL, t1);
         push_item(erms_pkg::CMD_POLL, t1 + $urandom_range(1, 20));
         clk_us = t1 + 100;
      end else begin
         k = $urandom_range(1, 4);
         repeat (k) begin
            if ($urandom_range(0, 1) == 1)
               push_item(2'($urandom_range(0, 3)), $urandom);
            else
               push_item(2'($urandom_range(0, 3)), clk_us + $urandom_range(0, 70000));
         end
      end
   endtask

   task automatic queue_random(input int n);
      int target;
      target = commands_pending.size() + n;
      while (commands_pending.size() < target)
         queue_measurement();
   endtask

   task automatic drain();
      while (commands_pending.size() != 0 || cmds_sent != cmds_taken ||
             readings_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic wait_csr();
      while (csr_pending.size() != 0 || csr_sent != csr_taken)
         @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_cfg(input logic [15:0] tmo, input logic [15:0] mx,
                            input logic [15:0] sc);
      drain();
      repeat (12) @(posedge clock);
      csr_pending.push_back('{erms_pkg::CSR_TIMEOUT, tmo});
      csr_pending.push_back('{erms_pkg::CSR_MAX_PULSE, mx});
      csr_pending.push_back('{erms_pkg::CSR_SCALE, sc});
      wait_csr();
      settings_used++;
   endtask

   initial begin
      clk_us = $urandom;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: idle, wrong phase, reserved command, wrap, zero width, timeout edge
      push_item(erms_pkg::CMD_POLL, 32'h0000_0000);
      push_item(erms_pkg::CMD_EDGE, 32'hFFFF_FFFF);
      push_item(CMD_RESERVED, 32'h5555_5555);
      push_item(erms_pkg::CMD_TRIGGER, 32'hFFFF_FFF0);
      push_item(erms_pkg::CMD_TRIGGER, 32'hFFFF_FFF1);
      push_item(erms_pkg::CMD_POLL, 32'hFFFF_FFF4);
      push_item(erms_pkg::CMD_EDGE, 32'hFFFF_FFF8);
      push_item(erms_pkg::CMD_POLL, 32'hFFFF_FFFA);
      push_item(erms_pkg::CMD_EDGE, 32'h0000_0010);
      push_item(erms_pkg::CMD_EDGE, 32'h0000_0020);
      push_item(erms_pkg::CMD_TRIGGER, 32'h0000_0021);
      push_item(erms_pkg::CMD_POLL, 32'h0000_0030);
      push_item(erms_pkg::CMD_TRIGGER, 32'h0000_1000);
      push_item(erms_pkg::CMD_EDGE, 32'h0000_2000);
      push_item(erms_pkg::CMD_EDGE, 32'h0000_2000);
      push_item(erms_pkg::CMD_POLL, 32'h0000_2001);
      push_item(erms_pkg::CMD_POLL, 32'h0000_2002);
      push_item(erms_pkg::CMD_TRIGGER, 32'h0001_0000);
      push_item(erms_pkg::CMD_POLL, 32'h0001_0000 + 32'd37999);
      push_item(erms_pkg::CMD_POLL, 32'h0001_0000 + 32'd38000);
      push_item(erms_pkg::CMD_POLL, 32'h0002_0000);
      push_item(erms_pkg::CMD_TRIGGER, 32'hAAAA_AAAA);
      push_item(erms_pkg::CMD_EDGE, 32'hAAAA_AAAB);
      push_item(erms_pkg::CMD_EDGE, 32'hAAAA_AAAB + 32'd40000);
      push_item(erms_pkg::CMD_POLL, 32'hAAAA_AAAB + 32'd40001);
      queue_random(150);

      write_cfg(16'h0000, 16'h0000, 16'h0000);
      csr_pending.push_back('{CSR_UNUSED, 16'hFFFF});
      wait_csr();
      queue_random(50);

      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      write_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_random(150);

      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      write_cfg(16'd1, 16'd1, 16'd1);
      queue_random(50);

      write_cfg(16'($urandom_range(200, 60000)), 16'($urandom_range(50, 65535)),
                16'($urandom_range(1, 4095)));
      queue_random(100);
      drain();
      queue_random(100);

      write_cfg(erms_pkg::TIMEOUT_RST, erms_pkg::MAX_PULSE_RST, 16'(erms_pkg::SCALE_RST));
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      queue_random(150);

      drain();
      repeat (20) @(posedge clock);
      if (readings_due.size() != 0)
         report($sformatf("%0d expected results never arrived", readings_due.size()));

      $display("Checked %0d results across %0d register settings.",
               readings_checked, settings_used);
      $display("Distance updates: %0d, lost or rejected measurements: %0d.",
               distance_updates, losses);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/erms_pkg.sv
rtl/core/erms_ctrl.sv
rtl/core/erms_dp.sv
rtl/core/echo_ranger_median_smooth.sv
tb/tb_top.sv
